// ----- hdl/ipv4ddf_pkg.sv -----
package ipv4ddf_pkg;

    // default depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [5:0] DOT_CHAR  = 6'd46;
    localparam logic [5:0] ZERO_CHAR = 6'd48;

    // character position inside one byte's text
    localparam logic [1:0] POS_ONE = 2'd0;
    localparam logic [1:0] POS_TEN = 2'd1;
    localparam logic [1:0] POS_HUN = 2'd2;
    localparam logic [1:0] POS_DOT = 2'd3;

    // byte index, most significant byte printed first
    localparam logic [1:0] BYTE_MSB = 2'd3;
    localparam logic [1:0] BYTE_LSB = 2'd0;

    typedef struct packed {
        logic [1:0] top;   // first position to print
        logic [3:0] hun;
        logic [3:0] ten;
        logic [3:0] one;
    } t_byte_txt;

    typedef struct packed {
        t_byte_txt [3:0] byt;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // binary to bcd by shift and add-3, then digit count
    function automatic t_byte_txt byte_to_txt(input logic [7:0] v);
        logic [11:0] bcd;
        t_byte_txt   r;
        bcd = '0;
        for (int i = 7; i >= 0; i--) begin
            if (bcd[3:0] >= 4'd5) begin
                bcd[3:0] = bcd[3:0] + 4'd3;
            end
            if (bcd[7:4] >= 4'd5) begin
                bcd[7:4] = bcd[7:4] + 4'd3;
            end
            if (bcd[11:8] >= 4'd5) begin
                bcd[11:8] = bcd[11:8] + 4'd3;
            end
            bcd = {bcd[10:0], v[i]};
        end
        r.hun = bcd[11:8];
        r.ten = bcd[7:4];
        r.one = bcd[3:0];
        if (r.hun != 4'd0) begin
            r.top = POS_HUN;
        end else if (r.ten != 4'd0) begin
            r.top = POS_TEN;
        end else begin
            r.top = POS_ONE;
        end
        return r;
    endfunction

endpackage

// ----- hdl/ipv4ddf_front.sv -----
module ipv4ddf_front (
    input  logic                 i_valid,
    input  logic [31:0]          i_address,
    output logic                 o_stall,
    input  ipv4ddf_pkg::t_q_stat i_q_stat,
    output logic                 o_push,
    output ipv4ddf_pkg::t_item   o_entry
);

    // split the address into bytes and convert each to decimal digits
    always_comb begin
        for (int b = 0; b < 4; b++) begin
            o_entry.byt[b] = ipv4ddf_pkg::byte_to_txt(i_address[8*b +: 8]);
        end
    end

    assign o_stall = i_q_stat.full;
    assign o_push  = i_valid && !i_q_stat.full;

endmodule

// ----- hdl/ipv4ddf_fifo.sv -----
module ipv4ddf_fifo #(
    parameter int unsigned DEPTH = ipv4ddf_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  ipv4ddf_pkg::t_item   i_entry,
    input  logic                 i_pop,
    output ipv4ddf_pkg::t_item   o_head,
    output ipv4ddf_pkg::t_q_stat o_q_stat
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    ipv4ddf_pkg::t_item r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_q_stat.full  = (r_count == FULL_CNT);
    assign o_q_stat.empty = (r_count == '0);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count above depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not grow on push");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");

endmodule

// ----- hdl/ipv4ddf_back.sv -----
module ipv4ddf_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ipv4ddf_pkg::t_q_stat i_q_stat,
    input  ipv4ddf_pkg::t_item   i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [5:0]           o_text_char,
    output logic                 o_last_char
);

    logic [1:0] r_byte, n_byte;
    logic [1:0] r_pos, n_pos;
    logic       r_fresh, n_fresh;
    logic       r_out_valid, n_out_valid;
    logic [5:0] r_char;
    logic       r_last;

    ipv4ddf_pkg::t_byte_txt cur;
    logic [1:0] eff_pos;
    logic [5:0] ch_now;
    logic       last_now;
    logic       take;

    assign cur      = i_head.byt[r_byte];
    assign eff_pos  = r_fresh ? cur.top : r_pos;
    assign take     = !i_q_stat.empty && (!r_out_valid || !i_stall);
    assign last_now = (r_byte == ipv4ddf_pkg::BYTE_LSB) && (eff_pos == ipv4ddf_pkg::POS_ONE);

    always_comb begin
        case (eff_pos)
            ipv4ddf_pkg::POS_HUN: ch_now = ipv4ddf_pkg::ZERO_CHAR + {2'b00, cur.hun};
            ipv4ddf_pkg::POS_TEN: ch_now = ipv4ddf_pkg::ZERO_CHAR + {2'b00, cur.ten};
            ipv4ddf_pkg::POS_ONE: ch_now = ipv4ddf_pkg::ZERO_CHAR + {2'b00, cur.one};
            default:              ch_now = ipv4ddf_pkg::DOT_CHAR;
        endcase
    end

    // walk bytes msb first, digits high to low, dot between bytes
    always_comb begin
        n_byte  = r_byte;
        n_pos   = r_pos;
        n_fresh = r_fresh;
        if (take) begin
            if (eff_pos == ipv4ddf_pkg::POS_DOT) begin
                n_byte  = r_byte - 1'b1;
                n_fresh = 1'b1;
            end else if (eff_pos == ipv4ddf_pkg::POS_ONE) begin
                if (r_byte == ipv4ddf_pkg::BYTE_LSB) begin
                    n_byte  = ipv4ddf_pkg::BYTE_MSB;
                    n_fresh = 1'b1;
                end else begin
                    n_pos   = ipv4ddf_pkg::POS_DOT;
                    n_fresh = 1'b0;
                end
            end else begin
                n_pos   = eff_pos - 1'b1;
                n_fresh = 1'b0;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (take) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte      <= ipv4ddf_pkg::BYTE_MSB;
            r_pos       <= ipv4ddf_pkg::POS_ONE;
            r_fresh     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_byte      <= n_byte;
            r_pos       <= n_pos;
            r_fresh     <= n_fresh;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_char <= ch_now;
            r_last <= last_now;
        end
    end

    assign o_pop       = take && last_now;
    assign o_valid     = r_out_valid;
    assign o_text_char = r_char;
    assign o_last_char = r_last;

    a_last_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_last |-> r_char != ipv4ddf_pkg::DOT_CHAR)
        else $error("last beat is a dot");

    a_dot_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && eff_pos == ipv4ddf_pkg::POS_DOT |=> r_fresh && r_byte == $past(r_byte - 2'd1))
        else $error("dot did not advance to next byte");

    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_fresh && r_byte == ipv4ddf_pkg::BYTE_MSB)
        else $error("sequencer did not restart after last beat");

endmodule

// ----- hdl/ipv4_dotted_decimal_formatter_top.sv -----
// with the back idle, an accepted address is written into the queue, and its first character
// is then taken from the queue head into the back's output register
// throughput: one character beat per cycle while the receiver does not stall, 7 to 15 beats
// per address by its text length; the single-character output register sets this
// the front takes a new address whenever the queue has room, even while the back prints
// reset: synchronous, active low; clears queue pointers, sequencer and output valid
module ipv4_dotted_decimal_formatter_top #(
    parameter int unsigned QUEUE_DEPTH = ipv4ddf_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // address channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_address,
    // character channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_text_char,
    output logic        o_last_char
);

    // queue status seen by both sides
    ipv4ddf_pkg::t_q_stat q_stat;
    // decimal digits of all four bytes, one queue entry per address
    ipv4ddf_pkg::t_item   push_entry;
    ipv4ddf_pkg::t_item   head_entry;
    logic                 push;
    logic                 pop;

    // front: converts each byte to decimal digits and a digit count
    ipv4ddf_front u_front (
        .i_valid   (i_valid),
        .i_address (i_address),
        .o_stall   (o_stall),
        .i_q_stat  (q_stat),
        .o_push    (push),
        .o_entry   (push_entry)
    );

    // short queue decouples address intake from character output
    ipv4ddf_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_head   (head_entry),
        .o_q_stat (q_stat)
    );

    // back: one character per beat, pops the entry on the last one
    ipv4ddf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_head      (head_entry),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char)
    );

endmodule

// ----- bench/tb_ipv4_dotted_decimal_formatter_top.sv -----
module tb_ipv4_dotted_decimal_formatter_top;

    // cycles with no beat on either channel before the run is called dead
    localparam int unsigned STALL_LIMIT = 2000;
    // length of the long receiver hold-off, in cycles
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    // percent of cycles in which a side idles
    localparam int unsigned IDLE_PCT = 29;
    // cycles to let pass after the last character arrived
    localparam int unsigned DRAIN_CYCLES = 8;

    // one expected character beat
    typedef struct packed {
        logic [5:0] text_char;
        logic       last_char;
    } t_char_beat;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [31:0] i_address   = '0;
    logic        i_stall     = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [5:0]  o_text_char;
    logic        o_last_char;

    // characters still owed by the block, oldest first
    t_char_beat  expected_text[$];
    int unsigned mismatch_count = 0;

    // idle controls, flipped by the test tasks
    bit send_idle_en = 1'b1;
    bit recv_idle_en = 1'b1;

    // hold-off request: toggled by a test, seen by the receiver process
    bit          hold_req  = 1'b0;
    bit          hold_seen = 1'b0;
    int unsigned hold_left = 0;

    int unsigned quiet_cycles = 0;

    ipv4_dotted_decimal_formatter_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_address   (i_address),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor: dotted-decimal text of one address, msb byte first,
    // no leading zeros, dot after the first three bytes
    // ------------------------------------------------------------------
    task automatic push_address_text(input logic [31:0] addr);
        logic [7:0]  byte_val;
        t_char_beat  beat;
        t_char_beat  text[$];
        for (int k = 3; k >= 0; k--) begin
            byte_val = addr[8*k +: 8];
            if (byte_val >= 8'd100) begin
                beat.text_char = ipv4ddf_pkg::ZERO_CHAR + 6'(byte_val / 100);
                beat.last_char = 1'b0;
                text.push_back(beat);
            end
            if (byte_val >= 8'd10) begin
                beat.text_char = ipv4ddf_pkg::ZERO_CHAR + 6'((byte_val / 10) % 10);
                beat.last_char = 1'b0;
                text.push_back(beat);
            end
            beat.text_char = ipv4ddf_pkg::ZERO_CHAR + 6'(byte_val % 10);
            beat.last_char = 1'b0;
            text.push_back(beat);
            if (k != 0) begin
                beat.text_char = ipv4ddf_pkg::DOT_CHAR;
                beat.last_char = 1'b0;
                text.push_back(beat);
            end
        end
        // the final character carries the last flag
        text[text.size() - 1].last_char = 1'b1;
        foreach (text[i]) expected_text.push_back(text[i]);
    endtask

    // ------------------------------------------------------------------
    // address sender: optional idle cycles, then offer the beat and hold
    // it until accepted; valid stays high on exit so back-to-back beats
    // need no second assignment in one step
    // ------------------------------------------------------------------
    task automatic send_address(input logic [31:0] addr);
        while (send_idle_en && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_address <= addr;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        // accepted at this edge
        push_address_text(addr);
    endtask

    // byte drawn by digit-count class so short and long texts both show up
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(3))
            0:       return 8'($urandom_range(0, 9));
            1:       return 8'($urandom_range(10, 99));
            2:       return 8'($urandom_range(100, 255));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_address();
        if ($urandom_range(3) == 0) return $urandom;
        return {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
    endfunction

    // ------------------------------------------------------------------
    // character receiver: random stall, or a long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_OFF_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (recv_idle_en) begin
            i_stall <= ($urandom_range(99) < IDLE_PCT);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // character checker: each accepted beat against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_char_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_text.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected character beat: text_char %0d last_char %0b",
                         $time, o_text_char, o_last_char);
            end else begin
                want = expected_text.pop_front();
                if (o_text_char !== want.text_char) begin
                    mismatch_count++;
                    $display("%0t: text_char mismatch: expected %0d actual %0d",
                             $time, want.text_char, o_text_char);
                end
                if (o_last_char !== want.last_char) begin
                    mismatch_count++;
                    $display("%0t: last_char mismatch: expected %0b actual %0b",
                             $time, want.last_char, o_last_char);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: counts cycles with no beat on either channel
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_ipv4_dotted_decimal_formatter_top: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // extremes, zero bytes, every digit-count boundary, single bits
    task automatic test_directed_text();
        send_address(32'h0000_0000);           // all zero bytes, shortest text
        send_address(32'hFFFF_FFFF);           // 255.255.255.255, longest text
        send_address({8'd10, 8'd0, 8'd0, 8'd1});
        send_address({8'd100, 8'd10, 8'd9, 8'd0});
        send_address({8'd99, 8'd199, 8'd200, 8'd249});
        send_address({8'd250, 8'd1, 8'd101, 8'd110});
        send_address({8'd192, 8'd168, 8'd1, 8'd254});
        send_address({8'd1, 8'd22, 8'd133, 8'd99});
        send_address(32'h8000_0000);
        send_address(32'h0000_0001);
        send_address(32'hAAAA_AAAA);
        send_address(32'h5555_5555);
        send_address({8'd0, 8'd255, 8'd0, 8'd255});
        send_address({8'd9, 8'd90, 8'd190, 8'd109});
    endtask

    // random addresses with both sides idling at random
    task automatic test_random_addresses(input int unsigned count);
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        repeat (count) send_address(pick_address());
    endtask

    // full-rate stretch, neither side idles
    task automatic test_no_idle_stretch(input int unsigned count);
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
        repeat (count) send_address(pick_address());
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
    endtask

    // receiver holds off while the sender keeps offering, so the block
    // fills up and stalls its address input
    task automatic test_output_hold_off();
        send_idle_en = 1'b0;
        hold_req <= ~hold_req;
        repeat (20) send_address(pick_address());
        send_idle_en = 1'b1;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_text();
        test_random_addresses(150);
        test_output_hold_off();
        test_no_idle_stretch(100);
        test_random_addresses(130);

        // all addresses sent; drop valid and drain the text
        i_valid <= 1'b0;
        while (expected_text.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("tb_ipv4_dotted_decimal_formatter_top: PASS");
        end else begin
            $display("tb_ipv4_dotted_decimal_formatter_top: FAIL");
        end
        $finish;
    end

endmodule
